[rtl/core/mvm_pkg.sv]
package mvm_pkg;

  localparam int COL_W  = 10;
  localparam int VAL_W  = 32;
  localparam int LEN_W  = 11;
  localparam int ROW_W  = 16;
  localparam int ACC_W  = 64;

  localparam int MAX_COLUMNS_DEF = 1024;
  localparam int LEN_RESET       = 1024;

  localparam logic FUNC_LOAD   = 1'b0;
  localparam logic FUNC_MATRIX = 1'b1;

  typedef struct packed {
    logic               func;
    logic [COL_W-1:0]   column;
    logic signed [VAL_W-1:0] value;
  } mvm_in_t;

  typedef struct packed {
    logic [ROW_W-1:0]        row_index;
    logic signed [ACC_W-1:0] dot_product;
    logic                    saturated;
  } mvm_out_t;

  // matrix element after the vector read has been issued
  typedef struct packed {
    logic                    valid;
    logic                    last;
    logic signed [VAL_W-1:0] value;
  } mvm_s1_t;

endpackage

[rtl/core/mvm_vstore.sv]
module mvm_vstore
  import mvm_pkg::*;
#(
  parameter int DEPTH = MAX_COLUMNS_DEF,
  parameter int AW    = 10
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [VAL_W-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [VAL_W-1:0] rdata
);

  logic [VAL_W-1:0] mem [DEPTH];
  logic [VAL_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // hold read data while no read is issued
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/core/mvm_mac.sv]
module mvm_mac
  import mvm_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             adv,
  input  mvm_s1_t          s1,
  input  logic [VAL_W-1:0] vec_data,
  output logic             res_valid,
  output mvm_out_t         res
);

  logic                    v2_r, v2_nxt;
  logic                    last2_r;
  logic signed [ACC_W-1:0] prod2_r;
  logic signed [ACC_W-1:0] prod_nxt;
  logic signed [VAL_W-1:0] vec_s;

  logic signed [ACC_W-1:0] acc_r, acc_nxt;
  logic                    ovf_r, ovf_nxt;
  logic [ROW_W-1:0]        row_r, row_nxt;

  logic [ACC_W:0]          sum_wide;
  logic signed [ACC_W-1:0] sum_sat;
  logic                    sum_ovf;

  assign vec_s    = $signed(vec_data);
  assign prod_nxt = s1.value * vec_s;
  assign v2_nxt   = s1.valid;

  // saturating add on a one-bit-wider sum
  always_comb begin
    sum_wide = {acc_r[ACC_W-1], acc_r} + {prod2_r[ACC_W-1], prod2_r};
    sum_ovf  = sum_wide[ACC_W] != sum_wide[ACC_W-1];
    if (sum_ovf) begin
      sum_sat = sum_wide[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end else begin
      sum_sat = sum_wide[ACC_W-1:0];
    end
  end

  always_comb begin
    acc_nxt   = acc_r;
    ovf_nxt   = ovf_r;
    row_nxt   = row_r;
    res_valid = 1'b0;
    res.row_index   = row_r;
    res.dot_product = sum_sat;
    res.saturated   = ovf_r | sum_ovf;
    if (adv && v2_r) begin
      if (last2_r) begin
        res_valid = 1'b1;
        acc_nxt   = '0;
        ovf_nxt   = 1'b0;
        row_nxt   = row_r + ROW_W'(1);
      end else begin
        acc_nxt = sum_sat;
        ovf_nxt = ovf_r | sum_ovf;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r  <= 1'b0;
      acc_r <= '0;
      ovf_r <= 1'b0;
      row_r <= '0;
    end else begin
      if (adv) begin
        v2_r <= v2_nxt;
      end
      acc_r <= acc_nxt;
      ovf_r <= ovf_nxt;
      row_r <= row_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prod2_r <= prod_nxt;
      last2_r <= s1.last;
    end
  end

endmodule

[rtl/core/matrix_vector_multiply.sv]
// Streaming matrix-vector multiplier, signed Q16.16 in, saturated Q32.32 out.
// Input channel (in_valid/in_stall/in_data): func 0 requests a vector load
// into the column store, func 1 streams one matrix element, row by row.
// Each matrix element is multiplied by the stored vector element of its
// column and added to a saturating accumulator; the element in the last
// column of a row produces one output request with row number, dot product
// and a saturation flag. Elements beyond the row length are dropped.
// Throughput: one input request per cycle, back to back, while in_stall is low.
// An accepted last element passes the store read at the accepting edge, then
// the multiply register, then the accumulate into the output register. The
// accumulator loop is one 64-bit add and clamp per cycle.
// Config channel (cfg_valid/cfg_ready/cfg_data) writes the row length; write
// it only while no request is in flight.
// Reset (rst_n, synchronous) clears accumulator, row counter, flag and
// pipeline valids and restores row length 1024. The vector store is not
// cleared: load every column before streaming matrix rows.
// When out_stall holds a result, a second result lands in a skid register;
// with the skid full, in_stall rises and the pipeline freezes.
module matrix_vector_multiply
  import mvm_pkg::*;
#(
  parameter int MAX_COLUMNS = MAX_COLUMNS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  mvm_in_t          in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output mvm_out_t         out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [LEN_W-1:0] cfg_data
);

  // store depth is capped by the reach of the column field
  localparam int DEPTH   = (MAX_COLUMNS < (1 << COL_W)) ? MAX_COLUMNS : (1 << COL_W);
  localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LEN_MAX = (1 << LEN_W) - 1;
  localparam int CAP     = (MAX_COLUMNS < LEN_MAX) ? MAX_COLUMNS : LEN_MAX;
  localparam int LEN_RST = (LEN_RESET < CAP) ? LEN_RESET : CAP;
  localparam int BW      = 17;

  logic [LEN_W-1:0] eff_len_r, eff_len_nxt;
  logic             adv;
  logic             in_acc;
  logic             col_in_row;
  logic             col_in_store;
  logic             col_last;

  logic             vs_we;
  logic             vs_re;
  logic [VAL_W-1:0] vs_rdata;

  mvm_s1_t          s1_r, s1_nxt;

  logic             res_valid;
  mvm_out_t         res;
  logic             out_valid_r;
  mvm_out_t         out_r;
  logic             skid_valid_r;
  mvm_out_t         skid_r;
  logic             out_take;

  // -------------------------------------------------------------------------
  // configuration: store the clamped row length
  // -------------------------------------------------------------------------
  assign cfg_ready = 1'b1;

  always_comb begin
    priority if (cfg_data == '0) begin
      eff_len_nxt = LEN_W'(1);
    end else if (cfg_data > LEN_W'(CAP)) begin
      eff_len_nxt = LEN_W'(CAP);
    end else begin
      eff_len_nxt = cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eff_len_r <= LEN_W'(LEN_RST);
    end else if (cfg_valid && cfg_ready) begin
      eff_len_r <= eff_len_nxt;
    end
  end

  // -------------------------------------------------------------------------
  // request intake: vector loads write the store, matrix elements read it
  // -------------------------------------------------------------------------
  assign adv      = !skid_valid_r;
  assign in_stall = skid_valid_r;
  assign in_acc   = in_valid && !in_stall;

  assign col_in_row   = {1'b0, in_data.column} < eff_len_r;
  assign col_last     = {1'b0, in_data.column} == (eff_len_r - LEN_W'(1));
  assign col_in_store = BW'(in_data.column) < BW'(MAX_COLUMNS);

  assign vs_we = in_acc && (in_data.func == FUNC_LOAD) && col_in_store;
  assign vs_re = in_acc && (in_data.func == FUNC_MATRIX) && col_in_row;

  mvm_vstore #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_vstore (
    .clk   (clk),
    .we    (vs_we),
    .waddr (in_data.column[AW-1:0]),
    .wdata (in_data.value),
    .re    (vs_re),
    .raddr (in_data.column[AW-1:0]),
    .rdata (vs_rdata)
  );

  always_comb begin
    s1_nxt.valid = vs_re;
    s1_nxt.last  = col_last;
    s1_nxt.value = in_data.value;
  end

  // advance the read stage; hold it while frozen
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r <= '0;
    end else if (adv) begin
      s1_r <= s1_nxt;
    end
  end

  // -------------------------------------------------------------------------
  // multiply and accumulate
  // -------------------------------------------------------------------------
  mvm_mac u_mac (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .s1        (s1_r),
    .vec_data  (vs_rdata),
    .res_valid (res_valid),
    .res       (res)
  );

  // -------------------------------------------------------------------------
  // output register plus skid register
  // -------------------------------------------------------------------------
  assign out_take = out_valid_r && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      priority if (skid_valid_r) begin
        if (out_take) begin
          out_valid_r  <= 1'b1;
          skid_valid_r <= 1'b0;
        end
      end else if (res_valid) begin
        if (!out_valid_r || out_take) begin
          out_valid_r <= 1'b1;
        end else begin
          skid_valid_r <= 1'b1;
        end
      end else if (out_take) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    priority if (skid_valid_r) begin
      if (out_take) begin
        out_r <= skid_r;
      end
    end else if (res_valid) begin
      if (!out_valid_r || out_take) begin
        out_r <= res;
      end else begin
        skid_r <= res;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // -------------------------------------------------------------------------
  // assertions
  // -------------------------------------------------------------------------
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid register full while output register empty");

  a_freeze_holds_s1: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |=> $stable(s1_r))
    else $error("read stage moved while pipeline frozen");

  a_load_no_mac: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_data.func == FUNC_LOAD) |=> !s1_r.valid)
    else $error("vector load entered the multiply path");

  a_no_result_when_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> !res_valid)
    else $error("result produced while skid register full");

endmodule

[sim/matrix_vector_multiply_tb.sv]
module matrix_vector_multiply_tb;
  import mvm_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int DRAIN_CYCLES   = 8;
  localparam int WATCHDOG_LIMIT = 2000;  // cycles with no handshake at all
  localparam int RANDOM_ITEMS   = 1400;
  localparam int STALL_PCT      = 34;

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  mvm_in_t          in_data = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  mvm_out_t         out_data;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [LEN_W-1:0] cfg_data = '0;

  // stimulus side: requests waiting for the driver, and what the generator loaded
  mvm_in_t     pending_requests[$];
  bit          column_loaded[MAX_COLUMNS_DEF];
  int unsigned stream_len = LEN_RESET;
  int unsigned counted_items = 0;

  // predicted block state, advanced at each accepted request
  logic [VAL_W-1:0]        vector_copy[MAX_COLUMNS_DEF];
  logic signed [ACC_W-1:0] running_sum = '0;
  logic [ROW_W-1:0]        next_row = '0;
  logic                    clamp_seen = 1'b0;
  logic [LEN_W-1:0]        length_reg = LEN_W'(LEN_RESET);
  mvm_out_t                expected_rows[$];

  int unsigned fail_count = 0;
  int unsigned quiet_cycles = 0;
  logic [31:0] cycle_count = '0;

  matrix_vector_multiply i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  always #5 clk = ~clk;

  // Clamp the register to the columns the store actually has.
  function automatic int unsigned usable_columns(input logic [LEN_W-1:0] n);
    if (n == 0) return 1;
    if (n > MAX_COLUMNS_DEF) return MAX_COLUMNS_DEF;
    return n;
  endfunction

  // Random pacing, except for a quiet window while bits 11:10 of cycle_count are both set.
  function automatic bit take_break();
    if (cycle_count[11:10] == 2'b11) return 1'b0;
    return $urandom_range(99) < STALL_PCT;
  endfunction

  // Bias toward the Q16.16 extremes so rows saturate now and then.
  function automatic logic [VAL_W-1:0] pick_value();
    case ($urandom_range(7))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return VAL_W'($urandom_range(255));
      3: return -VAL_W'($urandom_range(1, 255));
      default: return $urandom();
    endcase
  endfunction

  // Advance the predicted state by one accepted request.
  task automatic predict_dot_product(input mvm_in_t req);
    int unsigned             len;
    logic signed [ACC_W-1:0] prod;
    logic signed [ACC_W-1:0] sum;
    mvm_out_t                row;
    if (req.func == FUNC_LOAD) begin
      vector_copy[req.column] = req.value;
      return;
    end
    len = usable_columns(length_reg);
    // drop elements past the end of the row
    if (req.column >= len) return;
    prod = longint'($signed(req.value)) * longint'($signed(vector_copy[req.column]));
    sum = running_sum + prod;
    if (running_sum[ACC_W-1] == prod[ACC_W-1] && sum[ACC_W-1] != prod[ACC_W-1]) begin
      sum = prod[ACC_W-1] ? ACC_MIN : ACC_MAX;
      clamp_seen = 1'b1;
    end
    running_sum = sum;
    if (req.column != len - 1) return;
    row.row_index   = next_row;
    row.dot_product = running_sum;
    row.saturated   = clamp_seen;
    expected_rows.push_back(row);
    running_sum = '0;
    clamp_seen  = 1'b0;
    next_row    = next_row + 1'b1;
  endtask

  task automatic push_load(input int unsigned col, input logic [VAL_W-1:0] val);
    mvm_in_t req;
    req.func   = FUNC_LOAD;
    req.column = COL_W'(col);
    req.value  = val;
    pending_requests.push_back(req);
    column_loaded[col] = 1'b1;
    counted_items++;
  endtask

  task automatic push_element(input int unsigned col, input logic [VAL_W-1:0] val);
    mvm_in_t req;
    req.func   = FUNC_MATRIX;
    req.column = COL_W'(col);
    req.value  = val;
    pending_requests.push_back(req);
    if (col < stream_len) counted_items++;
  endtask

  // Hold until every request is in and every row is out, then let the
  // pipeline flush any dropped elements still in flight.
  task automatic wait_until_idle();
    while (pending_requests.size() != 0 || in_valid || expected_rows.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_row_length(input logic [LEN_W-1:0] len);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= len;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid  <= 1'b0;
    length_reg = len;
    stream_len = usable_columns(len);
  endtask

  // One row of matrix elements: usually a full row in order for short lengths, else a
  // sparse pick of loaded columns; close it with the last column when asked.
  task automatic stream_row(input bit close_row);
    int unsigned cols[$];
    int unsigned c;
    int unsigned picks;
    if (stream_len <= 32 && $urandom_range(9) < 7) begin
      for (c = 0; c + 1 < stream_len; c++) cols.push_back(c);
    end else if (stream_len > 1) begin
      picks = $urandom_range(10);
      repeat (picks) begin
        c = $urandom_range(stream_len - 2);
        if (column_loaded[c]) cols.push_back(c);
      end
    end
    foreach (cols[i]) begin
      // sprinkle in vector reloads and out-of-row elements
      if ($urandom_range(99) < 8) begin
        if ($urandom_range(1) == 0 || stream_len == MAX_COLUMNS_DEF)
          push_load($urandom_range(MAX_COLUMNS_DEF - 1), pick_value());
        else
          push_element($urandom_range(stream_len, MAX_COLUMNS_DEF - 1), pick_value());
      end
      push_element(cols[i], pick_value());
    end
    if (close_row) push_element(stream_len - 1, pick_value());
  endtask

  task automatic random_phase();
    logic [LEN_W-1:0] len;
    int unsigned      r;
    int unsigned      c;
    r = $urandom_range(99);
    if (r < 10)      len = '0;
    else if (r < 20) len = LEN_W'(1);
    else if (r < 30) len = LEN_W'($urandom_range(MAX_COLUMNS_DEF + 1, 2047));
    else if (r < 35) len = LEN_W'(MAX_COLUMNS_DEF);
    else if (r < 42) len = LEN_W'($urandom_range(33, MAX_COLUMNS_DEF - 1));
    else             len = LEN_W'($urandom_range(2, 16));
    wait_until_idle();
    write_row_length(len);
    if (stream_len <= 32) begin
      for (c = 0; c < stream_len; c++) push_load(c, pick_value());
    end else begin
      repeat (8) push_load($urandom_range(stream_len - 2), pick_value());
      push_load(stream_len - 1, pick_value());
    end
    repeat ($urandom_range(2, 10)) stream_row(1'b1);
    // leave a row open now and then so the next length applies mid row
    if ($urandom_range(3) == 0) stream_row(1'b0);
  endtask

  // Driver: present the next request once the current one is taken.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) predict_dot_product(in_data);
      if (!in_valid || !in_stall) begin
        if (pending_requests.size() != 0 && !take_break()) begin
          in_valid <= 1'b1;
          in_data  <= pending_requests.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each accepted row against the oldest prediction.
  always @(posedge clk) begin
    mvm_out_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_rows.size() == 0) begin
          $error("unexpected row: row_index %0d, dot_product %0d",
                 out_data.row_index, $signed(out_data.dot_product));
          fail_count++;
        end else begin
          want = expected_rows.pop_front();
          if (out_data.row_index !== want.row_index) begin
            $error("row_index: expected %0d, actual %0d", want.row_index, out_data.row_index);
            fail_count++;
          end
          if (out_data.dot_product !== want.dot_product) begin
            $error("dot_product: expected %0d, actual %0d",
                   $signed(want.dot_product), $signed(out_data.dot_product));
            fail_count++;
          end
          if (out_data.saturated !== want.saturated) begin
            $error("saturated: expected %0b, actual %0b", want.saturated, out_data.saturated);
            fail_count++;
          end
        end
      end
      out_stall <= take_break();
    end
  end

  // Watchdog: any handshake on any channel resets the count.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("** matrix_vector_multiply: FAILED **");
      $finish;
    end
  end

  initial begin
    foreach (vector_copy[i]) vector_copy[i] = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Reset length of 1024: sparse rows that end on the top column.
    push_load(0, 32'h7FFF_FFFF);
    push_load(MAX_COLUMNS_DEF - 1, 32'h8000_0000);
    push_load(512, $urandom());
    push_element(0, 32'h8000_0000);
    push_element(512, 32'h0000_0001);
    push_element(MAX_COLUMNS_DEF - 1, 32'h8000_0000);
    push_element(MAX_COLUMNS_DEF - 1, 32'h7FFF_FFFF);

    // Above the store size: acts as the full store.
    wait_until_idle();
    write_row_length(11'd2047);
    push_element(MAX_COLUMNS_DEF - 1, 32'h0000_0001);

    // Zero acts as one column; anything past column 0 is dropped.
    wait_until_idle();
    write_row_length('0);
    push_element(0, 32'h8000_0000);
    push_element(700, 32'h0000_0005);
    push_element(1, 32'h0000_0003);

    // Four columns: positive clamp, with a vector reload inside the row.
    wait_until_idle();
    write_row_length(11'd4);
    for (int c = 0; c < 4; c++) push_load(c, 32'h8000_0000);
    push_element(0, 32'h8000_0000);
    push_element(1, 32'h8000_0000);
    push_load(2, 32'h7FFF_FFFF);
    push_element(2, 32'h8000_0000);
    push_element(3, 32'h8000_0000);

    // Negative clamp, then keep adding from the clamped value.
    push_element(0, 32'h7FFF_FFFF);
    push_element(1, 32'h7FFF_FFFF);
    push_element(0, 32'h7FFF_FFFF);
    push_element(2, 32'h7FFF_FFFF);
    push_element(3, 32'h7FFF_FFFF);

    // Shorten the row while one is open: the partial sum carries over.
    push_element(0, 32'h0000_0001);
    wait_until_idle();
    write_row_length(11'd2);
    push_element(1, 32'h8000_0000);

    counted_items = 0;
    while (counted_items < RANDOM_ITEMS) random_phase();

    wait_until_idle();
    if (fail_count == 0) begin
      $display("** matrix_vector_multiply: PASSED **");
    end else begin
      $display("** matrix_vector_multiply: FAILED **");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/core/mvm_pkg.sv
rtl/core/mvm_vstore.sv
rtl/core/mvm_mac.sv
rtl/core/matrix_vector_multiply.sv
sim/matrix_vector_multiply_tb.sv
